[hw/rtl/ioxst_pkg.sv]
`default_nettype none

package ioxst_pkg;

    // item operation codes
    localparam logic [1:0] OP_START = 2'd0;
    localparam logic [1:0] OP_WRITE = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;

    // configuration register indexes
    localparam logic [1:0] CFG_MAGNET  = 2'd0;
    localparam logic [1:0] CFG_STEPS   = 2'd1;
    localparam logic [1:0] CFG_SYMBOLS = 2'd2;

    // register reset values
    localparam logic [15:0] MAGNET_RESET  = 16'd730;
    localparam logic [15:0] STEPS_RESET   = 16'd2048;
    localparam logic [5:0]  SYMBOLS_RESET = 6'd48;

    // coil patterns, forward order
    localparam logic [3:0] COIL_PH0  = 4'd3;
    localparam logic [3:0] COIL_PH1  = 4'd9;
    localparam logic [3:0] COIL_PH2  = 4'd12;
    localparam logic [3:0] COIL_PH3  = 4'd6;
    localparam logic [3:0] COIL_IDLE = 4'hF;

    // shared divider sizing
    localparam int DIV_NUM_W = 24;
    localparam int DIV_DEN_W = 18;
    localparam int DIV_CNT_W = 5;
    localparam int SYM_W     = 6;
    localparam logic [DIV_CNT_W-1:0] MOD_STEPS  = 5'd16;
    localparam logic [DIV_CNT_W-1:0] CHAR_STEPS = 5'd24;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_MOD_WAIT,
        ST_STEP,
        ST_CHAR_START,
        ST_CHAR_WAIT,
        ST_PUBLISH
    } seq_state_t;

    typedef struct packed {
        logic                 start;
        logic [DIV_NUM_W-1:0] dividend;
        logic [DIV_DEN_W-1:0] divisor;
        logic [SYM_W-1:0]     modulus;
        logic [DIV_CNT_W-1:0] steps;
    } div_cmd_t;

    typedef struct packed {
        logic                 done;
        logic [DIV_DEN_W-1:0] rem;
        logic [SYM_W-1:0]     qmod;
    } div_rsp_t;

    typedef struct packed {
        logic [7:0]        read_data;
        logic signed [1:0] step_move;
    } port_status_t;

    // one coil transition: +1 forward, -1 back, 0 otherwise
    function automatic logic signed [1:0] coil_step(input logic [3:0] from_c,
                                                    input logic [3:0] to_c);
        logic signed [1:0] mv;
        mv = 2'sd0;
        case (from_c)
            COIL_PH0: begin
                if (to_c == COIL_PH1) mv = 2'sd1;
                else if (to_c == COIL_PH3) mv = -2'sd1;
            end
            COIL_PH1: begin
                if (to_c == COIL_PH2) mv = 2'sd1;
                else if (to_c == COIL_PH0) mv = -2'sd1;
            end
            COIL_PH2: begin
                if (to_c == COIL_PH3) mv = 2'sd1;
                else if (to_c == COIL_PH1) mv = -2'sd1;
            end
            COIL_PH3: begin
                if (to_c == COIL_PH0) mv = 2'sd1;
                else if (to_c == COIL_PH2) mv = -2'sd1;
            end
            default: mv = 2'sd0;
        endcase
        return mv;
    endfunction

endpackage

`default_nettype wire

[hw/rtl/ioxst_div_unit.sv]
`default_nettype none

// restoring divider, one quotient bit a cycle; also folds the quotient mod a small value
module ioxst_div_unit (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire ioxst_pkg::div_cmd_t div_cmd,
    output ioxst_pkg::div_rsp_t      div_rsp
);

    localparam int NW = ioxst_pkg::DIV_NUM_W;
    localparam int DW = ioxst_pkg::DIV_DEN_W;
    localparam int CW = ioxst_pkg::DIV_CNT_W;
    localparam int SW = ioxst_pkg::SYM_W;

    logic          busy_reg;
    logic [CW-1:0] count_reg;
    logic [DW-1:0] rem_reg, rem_next;
    logic [NW-1:0] num_reg;
    logic [DW-1:0] den_reg;
    logic [SW-1:0] mod_reg;
    logic [SW-1:0] qmod_reg, qmod_next;

    logic [DW:0]   shifted;
    logic [DW+1:0] diff;
    logic          ge;
    logic [SW:0]   qm2;

    // one trial subtraction
    always_comb begin
        shifted  = {rem_reg, num_reg[NW-1]};
        diff     = {1'b0, shifted} - {2'b00, den_reg};
        ge       = ~diff[DW+1];
        rem_next = ge ? diff[DW-1:0] : shifted[DW-1:0];
        qm2      = {qmod_reg, ge};
        qmod_next = (qm2 >= {1'b0, mod_reg}) ? SW'(qm2 - {1'b0, mod_reg}) : qm2[SW-1:0];
    end

    // iteration control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg  <= 1'b0;
            count_reg <= '0;
        end else if (div_cmd.start) begin
            busy_reg  <= 1'b1;
            count_reg <= div_cmd.steps - CW'(1);
        end else if (busy_reg) begin
            if (count_reg == '0) busy_reg <= 1'b0;
            else count_reg <= count_reg - CW'(1);
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        if (div_cmd.start) begin
            rem_reg  <= '0;
            num_reg  <= div_cmd.dividend;
            den_reg  <= div_cmd.divisor;
            mod_reg  <= div_cmd.modulus;
            qmod_reg <= '0;
        end else if (busy_reg) begin
            rem_reg  <= rem_next;
            num_reg  <= {num_reg[NW-2:0], 1'b0};
            qmod_reg <= qmod_next;
        end
    end

    assign div_rsp.done = busy_reg && (count_reg == '0);
    assign div_rsp.rem  = rem_reg;
    assign div_rsp.qmod = qmod_reg;

endmodule

`default_nettype wire

[hw/rtl/ioxst_port_regs.sv]
`default_nettype none

// byte counter, held bytes, port word and coil tracking
module ioxst_port_regs #(
    parameter int PIN_COUNT = 16
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               accept,
    input  wire logic [1:0]         op,
    input  wire logic [7:0]         write_byte,
    input  wire logic [15:0]        pin_levels,
    output logic [15:0]             port_word,
    output ioxst_pkg::port_status_t status
);

    localparam logic [15:0] PinMask = 16'((32'd1 << PIN_COUNT) - 32'd1);

    logic [15:0] port_word_reg, port_word_next;
    logic [7:0]  low_reg, low_next;
    logic [7:0]  high_reg, high_next;
    logic [1:0]  count_reg, count_next;
    logic [3:0]  coils_reg, coils_next;
    logic [15:0] levels;
    logic [3:0]  coils_new;
    logic        apply;

    // item decode
    always_comb begin
        low_next       = low_reg;
        high_next      = high_reg;
        count_next     = count_reg;
        port_word_next = port_word_reg;
        coils_next     = coils_reg;
        levels         = pin_levels & PinMask;
        status.read_data = 8'd0;
        status.step_move = 2'sd0;
        apply          = 1'b0;
        case (op)
            ioxst_pkg::OP_START: count_next = 2'd0;
            ioxst_pkg::OP_WRITE: begin
                if (count_reg == 2'd0) begin
                    low_next   = write_byte;
                    count_next = 2'd1;
                end else if (count_reg == 2'd1) begin
                    high_next  = write_byte;
                    count_next = 2'd2;
                end
                apply = count_next[1];
            end
            ioxst_pkg::OP_READ: begin
                if (count_reg == 2'd0) begin
                    count_next       = 2'd1;
                    status.read_data = levels[7:0];
                end else begin
                    count_next       = 2'd0;
                    status.read_data = levels[15:8];
                end
            end
            default: count_next = count_reg;
        endcase
        // word applied once both bytes are held; coils sit in bits 4 to 1 of the low byte
        coils_new = low_next[4:1];
        if (apply) begin
            port_word_next   = {high_next, low_next};
            status.step_move = ioxst_pkg::coil_step(coils_reg, coils_new);
            if (coils_new != ioxst_pkg::COIL_IDLE) coils_next = coils_new;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            port_word_reg <= 16'hFFFF;
            low_reg       <= 8'd0;
            high_reg      <= 8'd0;
            count_reg     <= 2'd0;
            coils_reg     <= ioxst_pkg::COIL_IDLE;
        end else if (accept) begin
            port_word_reg <= port_word_next;
            low_reg       <= low_next;
            high_reg      <= high_next;
            count_reg     <= count_next;
            coils_reg     <= coils_next;
        end
    end

    assign port_word = port_word_reg;

endmodule

`default_nettype wire

[hw/rtl/i2c_io_expander_stepper_tracker_top.sv]
// channel   | direction | ports
// ----------+-----------+---------------------------------------------------------
// input     | in        | s_valid s_ready s_op s_write_byte s_pin_levels
// result    | out       | m_valid m_ready m_read_data m_drive_low_mask m_step_position
//           |           | m_step_move m_char_index
// config    | in        | cfg_wr_en cfg_index cfg_wdata
//
// an item with no step runs from the transfer through the character pass to its result;
// a step adds a pass through the divider for the position mod steps_per_rotation first
// the character index comes from a divider pass, one quotient bit a cycle
// synchronous active-low reset; no clearing pass, ready in the first cycle after reset
// a result held on m_ stalls the sequencer, s_ready is high only while idle
`default_nettype none

module i2c_io_expander_stepper_tracker_top #(
    parameter int PIN_COUNT   = 16,
    parameter int MAX_SYMBOLS = 48
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic [1:0]         s_op,
    input  wire logic [7:0]         s_write_byte,
    input  wire logic [15:0]        s_pin_levels,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic [7:0]              m_read_data,
    output logic [15:0]             m_drive_low_mask,
    output logic [15:0]             m_step_position,
    output logic signed [1:0]       m_step_move,
    output logic [5:0]              m_char_index,
    input  wire logic               cfg_wr_en,
    input  wire logic [1:0]         cfg_index,
    input  wire logic [15:0]        cfg_wdata
);

    localparam logic [15:0] PinMask   = 16'((32'd1 << PIN_COUNT) - 32'd1);
    localparam logic [15:0] SensorBit = 16'(32'd1 << (PIN_COUNT - 1));
    localparam logic [6:0]  MaxSym    = 7'(MAX_SYMBOLS);

    ioxst_pkg::seq_state_t state_reg, state_next;
    ioxst_pkg::div_cmd_t     div_cmd;
    ioxst_pkg::div_rsp_t     div_rsp;
    ioxst_pkg::port_status_t port_status;

    logic [15:0] magnet_reg, steps_reg;
    logic [5:0]  symbols_reg;
    logic [15:0] position_reg, position_next;
    logic        sensor_reg;
    logic [7:0]  rd_reg;
    logic signed [1:0] move_reg;
    logic [15:0] port_word;
    logic        s_accept, pub_load, step_en;
    logic        m_valid_reg;
    logic [7:0]  m_read_data_reg;
    logic [15:0] m_mask_reg, m_position_reg;
    logic signed [1:0] m_move_reg;
    logic [5:0]  m_char_reg;

    logic [16:0] s_eff;
    logic [6:0]  c_sat;
    logic [5:0]  c_eff;
    logic [21:0] pos_prod;
    logic [23:0] char_num;
    logic [16:0] p_mod, p_new;
    logic [15:0] mask_now;

    assign s_accept = s_valid && s_ready;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            magnet_reg  <= ioxst_pkg::MAGNET_RESET;
            steps_reg   <= ioxst_pkg::STEPS_RESET;
            symbols_reg <= ioxst_pkg::SYMBOLS_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                ioxst_pkg::CFG_MAGNET:  magnet_reg  <= cfg_wdata;
                ioxst_pkg::CFG_STEPS:   steps_reg   <= cfg_wdata;
                ioxst_pkg::CFG_SYMBOLS: symbols_reg <= cfg_wdata[5:0];
                default: ;
            endcase
        end
    end

    ioxst_port_regs #(
        .PIN_COUNT(PIN_COUNT)
    ) u_port (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .accept     (s_accept),
        .op         (s_op),
        .write_byte (s_write_byte),
        .pin_levels (s_pin_levels),
        .port_word  (port_word),
        .status     (port_status)
    );

    ioxst_div_unit u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .div_cmd (div_cmd),
        .div_rsp (div_rsp)
    );

    // effective rotation length and symbol count, and the character-pass dividend
    always_comb begin
        s_eff    = (steps_reg == 16'd0) ? 17'h10000 : {1'b0, steps_reg};
        c_sat    = ({1'b0, symbols_reg} > MaxSym) ? MaxSym : {1'b0, symbols_reg};
        c_eff    = (symbols_reg == 6'd0) ? 6'd1 : c_sat[5:0];
        pos_prod = 22'(position_reg) * 22'(c_eff);
        char_num = {1'b0, pos_prod, 1'b0} + 24'(s_eff);
    end

    // wrapped step from the reduced position
    always_comb begin
        p_mod = div_rsp.rem[16:0];
        if (move_reg > 2'sd0) p_new = (p_mod + 17'd1 == s_eff) ? 17'd0 : p_mod + 17'd1;
        else p_new = (p_mod == 17'd0) ? s_eff - 17'd1 : p_mod - 17'd1;
        position_next = p_new[15:0];
    end

    // sequencer next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ioxst_pkg::ST_IDLE:
                if (s_accept) state_next = ioxst_pkg::ST_LOAD;
            ioxst_pkg::ST_LOAD:
                state_next = (move_reg != 2'sd0) ? ioxst_pkg::ST_MOD_WAIT
                                                 : ioxst_pkg::ST_CHAR_START;
            ioxst_pkg::ST_MOD_WAIT:
                if (div_rsp.done) state_next = ioxst_pkg::ST_STEP;
            ioxst_pkg::ST_STEP:
                state_next = ioxst_pkg::ST_CHAR_START;
            ioxst_pkg::ST_CHAR_START:
                state_next = ioxst_pkg::ST_CHAR_WAIT;
            ioxst_pkg::ST_CHAR_WAIT:
                if (div_rsp.done) state_next = ioxst_pkg::ST_PUBLISH;
            ioxst_pkg::ST_PUBLISH:
                if (!m_valid_reg || m_ready) state_next = ioxst_pkg::ST_IDLE;
            default:
                state_next = ioxst_pkg::ST_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb begin
        s_ready  = 1'b0;
        step_en  = 1'b0;
        pub_load = 1'b0;
        div_cmd  = '0;
        case (state_reg)
            ioxst_pkg::ST_IDLE: s_ready = 1'b1;
            ioxst_pkg::ST_LOAD: begin
                if (move_reg != 2'sd0) begin
                    div_cmd.start    = 1'b1;
                    div_cmd.dividend = {position_reg, 8'd0};
                    div_cmd.divisor  = {1'b0, s_eff};
                    div_cmd.modulus  = c_eff;
                    div_cmd.steps    = ioxst_pkg::MOD_STEPS;
                end
            end
            ioxst_pkg::ST_STEP: step_en = 1'b1;
            ioxst_pkg::ST_CHAR_START: begin
                div_cmd.start    = 1'b1;
                div_cmd.dividend = char_num;
                div_cmd.divisor  = {s_eff, 1'b0};
                div_cmd.modulus  = c_eff;
                div_cmd.steps    = ioxst_pkg::CHAR_STEPS;
            end
            ioxst_pkg::ST_PUBLISH: pub_load = !m_valid_reg || m_ready;
            default: ;
        endcase
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ioxst_pkg::ST_IDLE;
            position_reg <= 16'd0;
            sensor_reg   <= (ioxst_pkg::MAGNET_RESET == 16'd0);
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (step_en) begin
                position_reg <= position_next;
                sensor_reg   <= (position_next == magnet_reg);
            end
            if (pub_load) m_valid_reg <= 1'b1;
            else if (m_ready) m_valid_reg <= 1'b0;
        end
    end

    // per-item capture and result register
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            rd_reg   <= port_status.read_data;
            move_reg <= port_status.step_move;
        end
        if (pub_load) begin
            m_read_data_reg <= rd_reg;
            m_mask_reg      <= mask_now;
            m_position_reg  <= position_reg;
            m_move_reg      <= move_reg;
            m_char_reg      <= div_rsp.qmod;
        end
    end

    assign mask_now = ((~port_word) & PinMask & ~SensorBit) | (sensor_reg ? SensorBit : 16'd0);

    assign m_valid          = m_valid_reg;
    assign m_read_data      = m_read_data_reg;
    assign m_drive_low_mask = m_mask_reg;
    assign m_step_position  = m_position_reg;
    assign m_step_move      = m_move_reg;
    assign m_char_index     = m_char_reg;

    // divider only finishes while the sequencer waits for it
    a_done_in_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        div_rsp.done |-> (state_reg == ioxst_pkg::ST_MOD_WAIT ||
                          state_reg == ioxst_pkg::ST_CHAR_WAIT))
        else $error("divider finished outside a wait state");

    // a position update only follows a real step
    a_step_has_move: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ioxst_pkg::ST_STEP |-> move_reg != 2'sd0)
        else $error("position update without a step");

    // the reduced position stays below the rotation length
    a_mod_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ioxst_pkg::ST_STEP |-> {1'b0, div_rsp.rem} < {2'b00, s_eff})
        else $error("reduced position out of range");

    // a loaded result is offered in the next cycle
    a_publish_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        pub_load |=> m_valid_reg)
        else $error("result loaded but not offered");

    // a transfer in always starts the sequencer
    a_accept_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |=> state_reg == ioxst_pkg::ST_LOAD)
        else $error("transfer did not start the sequencer");

endmodule

`default_nettype wire
